// ===== rtl/core/cbf_pkg.sv =====
// Package: payload types, register indexes and defaults of the cross blur filter.
package cbf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int FRAME_WIDTH_W = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int MAX_VALUE_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int PORT_PIXEL_W = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE    = 2'd2;

    localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 16'd480;
    localparam logic [MAX_VALUE_W-1:0]    RST_MAX_VALUE    = 16'd255;

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [PORT_PIXEL_W-1:0] pixel_in;
    } sample_t;

    typedef struct packed {
        logic [PORT_PIXEL_W-1:0] pixel_out;
        logic                    frame_last;
    } result_t;

endpackage

// ===== rtl/core/cbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cross_blur_filter_with_borders_top.sv =====
// Top level of the cross blur filter: counters, line buffers, window and divide pipeline.
//
// Streams a grey frame in raster order and returns it blurred with a plus-shaped
// kernel: (n*center + n neighbors) / 2n, n being the number of neighbors inside the
// frame (4 inside, 3 on edges, 2 at corners), truncated and clamped to max_value.
// Output runs one row behind input: the pixel transaction at (r, c) releases the
// blurred pixel (r-1, c); pixels of row zero release nothing. After the last pixel
// of the frame, one drain transaction (cmd = 1) per column releases the bottom row,
// and frame_last marks its final pixel. Pixel transactions after the frame is full
// and drain transactions before it is full are swallowed without a result. The
// block takes one transaction per clock while the output is not stalled and no
// register is written; a result passes a registered sum stage, then a registered
// divide and clamp stage. Two line buffers of MAX_WIDTH entries hold the previous two
// rows; their read ports are addressed from the next column count, so the data
// for the next transaction is already registered when it arrives. Any register
// write restarts the frame and drops undrained pixels; sample_stall is held high
// in the cycle of a write. Write registers only while the block is idle. No
// clearing pass is needed after reset.
module cross_blur_filter_with_borders_top
    import cbf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WNUM_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WNUM_W > FRAME_WIDTH_W) ? WNUM_W : FRAME_WIDTH_W;
    localparam int P      = PIXEL_BITS;
    localparam int NUM_W  = P + 3;            // up to 8 pixel values
    localparam int HALF_W = P + 2;
    localparam int PROD_W = 2 * HALF_W;
    // ceil(2^NUM_W / 3): exact floor(x/3) for every x below 2^HALF_W
    localparam logic [HALF_W-1:0] RECIP3 = HALF_W'(((2 ** NUM_W) + 2) / 3);

    // divisor codes
    localparam logic [1:0] DIV4 = 2'd0;
    localparam logic [1:0] DIV6 = 2'd1;
    localparam logic [1:0] DIV8 = 2'd2;

    // ---------------- configuration ----------------
    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [MAX_VALUE_W-1:0]    max_value_reg;
    logic                      cfg_hit;

    assign cfg_hit = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) ||
                                (cfg_index == CFG_FRAME_HEIGHT) ||
                                (cfg_index == CFG_MAX_VALUE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            max_value_reg    <= RST_MAX_VALUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                CFG_MAX_VALUE:    max_value_reg    <= cfg_data[MAX_VALUE_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective geometry: width held to [2, MAX_WIDTH], height at least 2
    logic [CMP_W-1:0]          fw_ext;
    logic [CMP_W-1:0]          eff_w;
    logic [ADDR_W-1:0]         w_last;
    logic [FRAME_HEIGHT_W-1:0] eff_h;

    always_comb
    begin
        fw_ext = CMP_W'(frame_width_reg);
        if (fw_ext < CMP_W'(2))
        begin
            eff_w = CMP_W'(2);
        end
        else if (fw_ext > CMP_W'(MAX_WIDTH))
        begin
            eff_w = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
        w_last = ADDR_W'(eff_w - CMP_W'(1));
        eff_h  = (frame_height_reg < FRAME_HEIGHT_W'(2)) ? FRAME_HEIGHT_W'(2)
                                                           : frame_height_reg;
    end

    // ---------------- handshake ----------------
    logic out_valid_reg;
    logic advance;
    logic item_go;

    assign advance      = !(out_valid_reg && result_stall);
    assign sample_stall = !advance || cfg_we;
    assign item_go      = sample_valid && !sample_stall;

    // ---------------- position counters ----------------
    // One column count serves input and output: during the frame the output
    // runs exactly one row behind at the same column, during drain the input
    // column rests at zero.
    logic [ADDR_W-1:0]         col_reg, col_next;
    logic [FRAME_HEIGHT_W-1:0] row_reg, row_next;
    logic                      emit;
    logic                      mid_we;
    logic                      head_we;
    logic                      at_last_col;
    logic [P-1:0]              pix;

    assign pix         = sample.pixel_in[P-1:0];
    assign at_last_col = (col_reg == w_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        emit     = 1'b0;
        mid_we   = 1'b0;
        head_we  = 1'b0;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (item_go)
        begin
            if (sample.cmd == CMD_PIXEL)
            begin
                if (row_reg < eff_h)
                begin
                    emit    = (row_reg != '0);
                    mid_we  = 1'b1;
                    head_we = (col_reg == '0);
                    if (at_last_col)
                    begin
                        col_next = '0;
                        row_next = row_reg + FRAME_HEIGHT_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + ADDR_W'(1);
                    end
                end
            end
            else if (row_reg >= eff_h)
            begin
                emit = 1'b1;
                if (at_last_col)
                begin
                    // bottom row drained: next pixel opens a new frame
                    col_next = '0;
                    row_next = '0;
                end
                else
                begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line buffers ----------------
    // middle holds row r-1 (read one column ahead), upper holds row r-2.
    logic [ADDR_W-1:0] mid_raddr;
    logic [P-1:0]      mid_q;
    logic [P-1:0]      up_q;
    logic [P-1:0]      center;
    logic [P-1:0]      right;
    logic [P-1:0]      mid_fwd;
    logic              byp_reg;
    logic [P-1:0]      byp_data_reg;

    assign mid_raddr = col_next + ADDR_W'(1);

    cbf_ram #(
        .WIDTH(P),
        .DEPTH(MAX_WIDTH)
    ) u_mid_ram (
        .clk  (clk),
        .we   (mid_we),
        .waddr(col_reg),
        .wdata(pix),
        .raddr(mid_raddr),
        .rdata(mid_q)
    );

    cbf_ram #(
        .WIDTH(P),
        .DEPTH(MAX_WIDTH)
    ) u_up_ram (
        .clk  (clk),
        .we   (emit),
        .waddr(col_reg),
        .wdata(center),
        .raddr(col_next),
        .rdata(up_q)
    );

    // two-column frames read back the entry written at the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= mid_we && (col_reg == mid_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= pix;
    end

    assign mid_fwd = byp_reg ? byp_data_reg : mid_q;

    // ---------------- window ----------------
    // head: column 0 of the last row written; left: the last output pixel;
    // right: its right neighbor along its row.
    logic [P-1:0] head_reg;
    logic [P-1:0] left_reg;
    logic [P-1:0] right_reg;
    logic         has_left;
    logic         has_right;
    logic         has_up;
    logic         has_below;

    assign has_left  = (col_reg != '0);
    assign has_right = !at_last_col;
    assign has_up    = (row_reg >= FRAME_HEIGHT_W'(2));
    assign has_below = (sample.cmd == CMD_PIXEL);
    assign center    = has_left ? right_reg : head_reg;
    assign right     = has_right ? mid_fwd : '0;

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_reg <= pix;
        end
        if (emit)
        begin
            left_reg  <= center;
            right_reg <= right;
        end
    end

    // ---------------- stage 1: weighted sum ----------------
    logic [NUM_W-1:0] num;
    logic [1:0]       div_code;
    logic [2:0]       n_count;
    logic             last_pix;

    always_comb
    begin
        num = '0;
        if (has_left)
        begin
            num = num + NUM_W'(center) + NUM_W'(left_reg);
        end
        if (has_right)
        begin
            num = num + NUM_W'(center) + NUM_W'(right);
        end
        if (has_up)
        begin
            num = num + NUM_W'(center) + NUM_W'(up_q);
        end
        if (has_below)
        begin
            num = num + NUM_W'(center) + NUM_W'(pix);
        end
        n_count = 3'(has_left) + 3'(has_right) + 3'(has_up) + 3'(has_below);
        case (n_count)
            3'd2:    div_code = DIV4;
            3'd3:    div_code = DIV6;
            default: div_code = DIV8;
        endcase
        // only a drain reaches the bottom row
        last_pix = !has_below && at_last_col;
    end

    logic             s1_valid_reg;
    logic [NUM_W-1:0] s1_num_reg;
    logic [1:0]       s1_div_reg;
    logic             s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= emit;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_num_reg  <= num;
            s1_div_reg  <= div_code;
            s1_last_reg <= last_pix;
        end
    end

    // ---------------- stage 2: divide and clamp ----------------
    logic [HALF_W-1:0]      half;
    logic [PROD_W-1:0]      prod;
    logic [P-1:0]           quot;
    logic [MAX_VALUE_W-1:0] quot_ext;
    logic [MAX_VALUE_W-1:0] clamped;
    result_t                out_reg;

    always_comb
    begin
        // x/6 = (x/2)/3, the /3 by reciprocal multiply
        half = s1_num_reg[NUM_W-1:1];
        prod = PROD_W'(half) * PROD_W'(RECIP3);
        case (s1_div_reg)
            DIV4:    quot = s1_num_reg[P+1:2];
            DIV6:    quot = prod[NUM_W+P-1:NUM_W];
            default: quot = s1_num_reg[P+2:3];
        endcase
        quot_ext = MAX_VALUE_W'(quot);
        clamped  = (quot_ext > max_value_reg) ? max_value_reg : quot_ext;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.pixel_out  <= PORT_PIXEL_W'(clamped);
            out_reg.frame_last <= s1_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ---------------- assertions ----------------
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last)
        else $error("column count beyond frame width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= eff_h)
        else $error("row count beyond frame height");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !has_below && at_last_col |=> row_reg == '0 && col_reg == '0)
        else $error("last drain did not restart the frame");

    a_bypass_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> w_last == ADDR_W'(1))
        else $error("line buffer bypass outside two-column frame");

    a_last_drain_only: assert property (@(posedge clk) disable iff (!rst_n)
        emit && has_below |-> !last_pix)
        else $error("frame end flagged on a pixel transaction");

endmodule
